[sv/tpp_pkg.sv]
// Shared types and constants of the terminal padding parser.
// Holds the controller/datapath command and status structs; no dependencies.
package tpp_pkg;

  localparam int HOLD_DEPTH = 32;
  localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
  localparam int ADDR_W     = $clog2(HOLD_DEPTH);
  localparam int HOLD_SLOTS = 2 ** ADDR_W;

  localparam int CHAR_W      = 8;
  localparam int LINES_W     = 16;
  localparam int PAD_W       = 32;
  localparam int DELAY_W     = 28;
  localparam int RATE_W      = 23;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 23;

  localparam logic [CFG_IDX_W-1:0] CFG_SOFT_FLOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PADDING_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_RATE    = 2'd2;

  localparam logic [RATE_W-1:0] LINE_RATE_RESET = 23'd9600;

  localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_GT     = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

  localparam logic [PAD_W-1:0] PAD_LIMIT = 32'd1000;
  // x / 10 == (x * RECIP) >> 35 for every 32-bit x.
  localparam logic [PAD_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int DIV10_SHIFT = 35;

  typedef enum logic [2:0] {
    PAD_KEEP,
    PAD_ZERO,
    PAD_DIGIT,
    PAD_MAC,
    PAD_ADD,
    PAD_MUL10,
    PAD_MUL_LINES,
    PAD_MUL_LINES10
  } pad_op_t;

  typedef enum logic [2:0] {
    SEL_DOLLAR,
    SEL_LT,
    SEL_HELD,
    SEL_INPUT,
    SEL_DELAY
  } out_sel_t;

  typedef struct packed {
    logic     capture;
    logic     commit_start;
    logic     set_delay;
    pad_op_t  pad_op;
    logic     hold_write;
    logic     ptr_clear;
    logic     ptr_inc;
    logic     out_load;
    out_sel_t out_sel;
    logic     out_last;
    logic     finish_clear;
    logic     finish_eos;
  } tpp_cmd_t;

  typedef struct packed {
    logic is_digit;
    logic is_dot;
    logic is_gt;
    logic is_lt;
    logic is_dollar;
    logic is_star;
    logic is_slash;
    logic eos;
    logic pad_ge_limit;
    logic held_full;
    logic held_nz;
    logic ptr_last;
    logic pad_ok;
    logic can_load;
  } tpp_stat_t;

endpackage

[sv/tpp_datapath.sv]
// Datapath of the terminal padding parser: input capture, padding value
// arithmetic, held-character memory, configuration and output register.
// Depends on tpp_pkg.
module tpp_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  tpp_pkg::tpp_cmd_t                   cmd,
  output tpp_pkg::tpp_stat_t                  st,
  input  logic [tpp_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  logic                                s_tlast,
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [tpp_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic                                m_tlast,
  output logic                                m_tuser,
  input  logic                                cfg_we,
  input  logic [tpp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tpp_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [tpp_pkg::CHAR_W-1:0]  in_char;
  logic                        in_eos;
  logic [tpp_pkg::LINES_W-1:0] in_lines;
  logic                        in_alert;

  logic                        soft_flow;
  logic [tpp_pkg::RATE_W-1:0]  padding_rate;
  logic [tpp_pkg::RATE_W-1:0]  line_rate;

  logic [tpp_pkg::PAD_W-1:0]   pad;
  logic [tpp_pkg::PAD_W-1:0]   pad_next;
  logic [tpp_pkg::CNT_W-1:0]   held_count;
  logic [tpp_pkg::CNT_W-1:0]   ptr;
  logic [tpp_pkg::CNT_W-1:0]   ptr_next;
  logic                        delay_en;
  logic                        string_start;

  logic [tpp_pkg::CHAR_W-1:0]  held_mem [tpp_pkg::HOLD_SLOTS];
  logic [tpp_pkg::CHAR_W-1:0]  rd_data;

  logic [63:0]                 div_prod;
  logic [3:0]                  digit;
  logic [tpp_pkg::PAD_W-1:0]   pad_x10;
  logic [19:0]                 lines_x10;
  logic [19:0]                 mul_b;
  logic [51:0]                 mul_full;
  logic                        start_delay;

  logic [tpp_pkg::CHAR_W-1:0]  out_char;
  logic [tpp_pkg::DELAY_W-1:0] out_delay;

  assign digit     = 4'(in_char - tpp_pkg::CH_ZERO);
  assign pad_x10   = (pad << 3) + (pad << 1);
  assign lines_x10 = (20'(in_lines) << 3) + (20'(in_lines) << 1);
  assign mul_b     = (cmd.pad_op == tpp_pkg::PAD_MUL_LINES10) ? lines_x10 : 20'(in_lines);
  assign mul_full  = pad * mul_b;

  assign start_delay = in_alert ||
                       (!soft_flow && (padding_rate != '0) && (line_rate >= padding_rate));

  always_comb begin
    unique case (cmd.pad_op)
      tpp_pkg::PAD_KEEP:        pad_next = pad;
      tpp_pkg::PAD_ZERO:        pad_next = '0;
      tpp_pkg::PAD_DIGIT:       pad_next = 32'(digit);
      tpp_pkg::PAD_MAC:         pad_next = pad_x10 + 32'(digit);
      tpp_pkg::PAD_ADD:         pad_next = pad + 32'(digit);
      tpp_pkg::PAD_MUL10:       pad_next = pad_x10;
      tpp_pkg::PAD_MUL_LINES,
      tpp_pkg::PAD_MUL_LINES10: pad_next = mul_full[tpp_pkg::PAD_W-1:0];
      default:                  pad_next = pad;
    endcase
  end

  always_comb begin
    if (cmd.ptr_clear) begin
      ptr_next = '0;
    end else if (cmd.ptr_inc) begin
      ptr_next = ptr + tpp_pkg::CNT_W'(1);
    end else begin
      ptr_next = ptr;
    end
  end

  assign st.is_digit     = (in_char >= tpp_pkg::CH_ZERO) && (in_char <= tpp_pkg::CH_NINE);
  assign st.is_dot       = (in_char == tpp_pkg::CH_DOT);
  assign st.is_gt        = (in_char == tpp_pkg::CH_GT);
  assign st.is_lt        = (in_char == tpp_pkg::CH_LT);
  assign st.is_dollar    = (in_char == tpp_pkg::CH_DOLLAR);
  assign st.is_star      = (in_char == tpp_pkg::CH_STAR);
  assign st.is_slash     = (in_char == tpp_pkg::CH_SLASH);
  assign st.eos          = in_eos;
  assign st.pad_ge_limit = (pad >= tpp_pkg::PAD_LIMIT);
  assign st.held_full    = (held_count >= tpp_pkg::CNT_W'(tpp_pkg::HOLD_DEPTH));
  assign st.held_nz      = (held_count != '0);
  assign st.ptr_last     = ((ptr + tpp_pkg::CNT_W'(1)) == held_count);
  // The value is read as signed: only a positive value produces a delay.
  assign st.pad_ok       = delay_en && (pad != '0) && !pad[tpp_pkg::PAD_W-1];
  assign st.can_load     = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_char  <= s_tdata[tpp_pkg::CHAR_W-1:0];
      in_lines <= s_tdata[tpp_pkg::CHAR_W +: tpp_pkg::LINES_W];
      in_eos   <= s_tlast;
      in_alert <= s_tuser;
    end
    if (cmd.hold_write) begin
      held_mem[held_count[tpp_pkg::ADDR_W-1:0]] <= in_char;
    end
    rd_data  <= held_mem[ptr_next[tpp_pkg::ADDR_W-1:0]];
    div_prod <= 64'(pad) * 64'(tpp_pkg::DIV10_RECIP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      soft_flow    <= 1'b0;
      padding_rate <= '0;
      line_rate    <= tpp_pkg::LINE_RATE_RESET;
      pad          <= '0;
      held_count   <= '0;
      ptr          <= '0;
      delay_en     <= 1'b0;
      string_start <= 1'b1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tpp_pkg::CFG_SOFT_FLOW:    soft_flow    <= cfg_data[0];
          tpp_pkg::CFG_PADDING_RATE: padding_rate <= cfg_data[tpp_pkg::RATE_W-1:0];
          tpp_pkg::CFG_LINE_RATE:    line_rate    <= cfg_data[tpp_pkg::RATE_W-1:0];
          default: ;
        endcase
      end
      ptr <= ptr_next;
      if (cmd.finish_clear) begin
        pad        <= '0;
        held_count <= '0;
      end else begin
        pad <= pad_next;
        if (cmd.hold_write) begin
          held_count <= held_count + tpp_pkg::CNT_W'(1);
        end
      end
      // A slash sets delay after the per-string decision has been taken.
      if (cmd.set_delay) begin
        delay_en <= 1'b1;
      end else if (cmd.commit_start && string_start) begin
        delay_en <= start_delay;
      end
      if (cmd.finish_eos) begin
        string_start <= 1'b1;
      end else if (cmd.commit_start) begin
        string_start <= 1'b0;
      end
    end
  end

  always_comb begin
    out_delay = '0;
    unique case (cmd.out_sel)
      tpp_pkg::SEL_DOLLAR: out_char = tpp_pkg::CH_DOLLAR;
      tpp_pkg::SEL_LT:     out_char = tpp_pkg::CH_LT;
      tpp_pkg::SEL_HELD:   out_char = rd_data;
      tpp_pkg::SEL_INPUT:  out_char = in_char;
      tpp_pkg::SEL_DELAY: begin
        out_char  = '0;
        out_delay = div_prod[tpp_pkg::DIV10_SHIFT +: tpp_pkg::DELAY_W];
      end
      default:             out_char = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {4'b0, out_delay, out_char};
      m_tuser <= (cmd.out_sel == tpp_pkg::SEL_DELAY);
      m_tlast <= cmd.out_last;
    end
  end

endmodule

[sv/tpp_ctrl.sv]
// Controller of the terminal padding parser: parse mode, per-item decode and
// the sequencer that issues result requests to the datapath. Depends on tpp_pkg.
module tpp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  tpp_pkg::tpp_stat_t st,
  output tpp_pkg::tpp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_REP_D,
    S_REP_L,
    S_REP_H,
    S_PD,
    S_PC,
    S_ED,
    S_DLY_MUL,
    S_DLY_EMIT
  } state_t;

  typedef enum logic [2:0] {
    M_NORMAL,
    M_DOLLAR,
    M_OPEN,
    M_INT,
    M_FRAC1,
    M_FRAC2,
    M_SUFFIX
  } mode_t;

  state_t state;
  state_t state_next;
  mode_t  mode;
  mode_t  mode_next;
  logic   pd_f;
  logic   pc_f;
  logic   ed_f;
  logic   clr_f;
  logic   eos_f;

  // Decode of the captured byte against the current mode.
  mode_t            mode_mid;
  tpp_pkg::pad_op_t dec_pad_op;
  logic             dec_set_delay;
  logic             dec_hold;
  logic             dec_done;
  logic             dec_fail;
  logic             dec_rep;
  logic             dec_pd;
  logic             dec_pc;
  logic             dec_ed;
  logic             dec_clr;
  logic             spec;
  logic             none_after_rep;

  function automatic state_t seg_next(input logic pd, input logic pc, input logic ed);
    if (pd) begin
      return S_PD;
    end else if (pc) begin
      return S_PC;
    end else if (ed) begin
      return S_ED;
    end
    return S_IDLE;
  endfunction

  function automatic logic in_spec(input mode_t m);
    return (m != M_NORMAL) && (m != M_DOLLAR);
  endfunction

  always_comb begin
    spec          = in_spec(mode);
    mode_mid      = mode;
    dec_pad_op    = tpp_pkg::PAD_KEEP;
    dec_set_delay = 1'b0;
    dec_hold      = 1'b0;
    dec_done      = spec && st.is_gt && (mode != M_OPEN);
    dec_fail      = 1'b0;
    dec_pd        = 1'b0;
    dec_pc        = 1'b0;
    dec_ed        = 1'b0;
    if (spec) begin
      if (dec_done) begin
        if (mode == M_INT) begin
          dec_pad_op = tpp_pkg::PAD_MUL10;
        end
        mode_mid = M_NORMAL;
      end else if (st.held_full) begin
        dec_fail = 1'b1;
      end else begin
        unique case (mode)
          M_OPEN: begin
            if (st.is_digit) begin
              dec_pad_op = tpp_pkg::PAD_DIGIT;
              mode_mid   = M_INT;
            end else if (st.is_dot) begin
              dec_pad_op = tpp_pkg::PAD_ZERO;
              mode_mid   = M_FRAC1;
            end else begin
              dec_fail = 1'b1;
            end
          end
          M_INT: begin
            if (st.is_digit) begin
              // The integer part stops taking digits once it reaches the limit.
              if (st.pad_ge_limit) begin
                dec_fail = 1'b1;
              end else begin
                dec_pad_op = tpp_pkg::PAD_MAC;
              end
            end else if (st.is_dot) begin
              dec_pad_op = tpp_pkg::PAD_MUL10;
              mode_mid   = M_FRAC1;
            end else if (st.is_star) begin
              dec_pad_op = tpp_pkg::PAD_MUL_LINES10;
              mode_mid   = M_SUFFIX;
            end else if (st.is_slash) begin
              dec_pad_op    = tpp_pkg::PAD_MUL10;
              dec_set_delay = 1'b1;
              mode_mid      = M_SUFFIX;
            end else begin
              dec_fail = 1'b1;
            end
          end
          default: begin
            if (st.is_digit && (mode == M_FRAC1)) begin
              dec_pad_op = tpp_pkg::PAD_ADD;
              mode_mid   = M_FRAC2;
            end else if (st.is_digit && (mode == M_FRAC2)) begin
              mode_mid = M_FRAC2;
            end else if (st.is_star) begin
              dec_pad_op = tpp_pkg::PAD_MUL_LINES;
              mode_mid   = M_SUFFIX;
            end else if (st.is_slash) begin
              dec_set_delay = 1'b1;
              mode_mid      = M_SUFFIX;
            end else begin
              dec_fail = 1'b1;
            end
          end
        endcase
        dec_hold = !dec_fail;
      end
    end
    // A failed spec is replayed and the byte is then handled as plain text.
    if (dec_fail) begin
      mode_mid = M_NORMAL;
    end
    if (!spec || dec_fail) begin
      if (mode_mid == M_DOLLAR) begin
        if (st.is_lt) begin
          mode_mid = M_OPEN;
        end else begin
          dec_pd   = 1'b1;
          dec_pc   = 1'b1;
          mode_mid = M_NORMAL;
        end
      end else if (st.is_dollar) begin
        mode_mid = M_DOLLAR;
      end else begin
        dec_pc = 1'b1;
      end
    end
    dec_ed  = st.eos && (mode_mid == M_DOLLAR);
    dec_rep = dec_fail || (st.eos && in_spec(mode_mid));
    dec_clr = dec_rep || dec_done || st.eos;
  end

  assign none_after_rep = !pd_f && !pc_f && !ed_f;

  always_comb begin
    cmd        = '0;
    cmd.pad_op = tpp_pkg::PAD_KEEP;
    cmd.out_sel = tpp_pkg::SEL_DOLLAR;
    s_tready   = 1'b0;
    state_next = state;
    mode_next  = mode;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.commit_start = 1'b1;
        cmd.ptr_clear    = 1'b1;
        cmd.pad_op       = dec_pad_op;
        cmd.set_delay    = dec_set_delay;
        cmd.hold_write   = dec_hold;
        mode_next        = st.eos ? M_NORMAL : mode_mid;
        if (dec_done) begin
          state_next = S_DLY_MUL;
        end else if (dec_rep) begin
          state_next = S_REP_D;
        end else begin
          state_next = seg_next(dec_pd, dec_pc, dec_ed);
        end
        if (state_next == S_IDLE) begin
          cmd.finish_clear = dec_clr;
          cmd.finish_eos   = st.eos;
        end
      end
      S_REP_D: begin
        if (st.can_load) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = tpp_pkg::SEL_DOLLAR;
          state_next   = S_REP_L;
        end
      end
      S_REP_L: begin
        if (st.can_load) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = tpp_pkg::SEL_LT;
          cmd.out_last = !st.held_nz && none_after_rep;
          state_next   = st.held_nz ? S_REP_H : seg_next(pd_f, pc_f, ed_f);
        end
      end
      S_REP_H: begin
        if (st.can_load) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = tpp_pkg::SEL_HELD;
          cmd.out_last = st.ptr_last && none_after_rep;
          cmd.ptr_inc  = 1'b1;
          state_next   = st.ptr_last ? seg_next(pd_f, pc_f, ed_f) : S_REP_H;
        end
      end
      S_PD: begin
        if (st.can_load) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = tpp_pkg::SEL_DOLLAR;
          cmd.out_last = !pc_f && !ed_f;
          state_next   = seg_next(1'b0, pc_f, ed_f);
        end
      end
      S_PC: begin
        if (st.can_load) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = tpp_pkg::SEL_INPUT;
          cmd.out_last = !ed_f;
          state_next   = seg_next(1'b0, 1'b0, ed_f);
        end
      end
      S_ED: begin
        if (st.can_load) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = tpp_pkg::SEL_DOLLAR;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_DLY_MUL: begin
        state_next = st.pad_ok ? S_DLY_EMIT : S_IDLE;
      end
      S_DLY_EMIT: begin
        if (st.can_load) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = tpp_pkg::SEL_DELAY;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if ((state != S_IDLE) && (state != S_EVAL) && (state_next == S_IDLE)) begin
      cmd.finish_clear = clr_f;
      cmd.finish_eos   = eos_f;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= M_NORMAL;
      pd_f  <= 1'b0;
      pc_f  <= 1'b0;
      ed_f  <= 1'b0;
      clr_f <= 1'b0;
      eos_f <= 1'b0;
    end else begin
      state <= state_next;
      mode  <= mode_next;
      if (state == S_EVAL) begin
        pd_f  <= dec_pd;
        pc_f  <= dec_pc;
        ed_f  <= dec_ed;
        clr_f <= dec_clr;
        eos_f <= st.eos;
      end
    end
  end

endmodule

[sv/terminal_padding_parser_unit.sv]
// Top level of the terminal padding parser: joins the controller and the
// datapath. Depends on tpp_pkg, tpp_ctrl and tpp_datapath.
//
// Usage: bytes of a terminal control string arrive on the s_ channel, one
// request each, with tlast on the last byte of the string. Results leave on
// the m_ channel: a character to send or a delay in milliseconds, with tlast
// on the final result caused by each input byte. A byte may cause no result.
// Padding specs of the form $<value*/> are taken out of the stream.
// Each byte passes an accept state (S_IDLE) and a decode state (S_EVAL), then
// a result state for each result it causes; a closing '>' adds the state
// S_DLY_MUL for the reciprocal multiply that divides the value by ten, even
// when no delay results. A failed spec replays '$', '<' and every held byte,
// one per cycle while the receiver takes them.
// A stalled receiver holds the output register and the sequencer waits; the
// next byte is accepted once the last result of the current one is loaded.
// Reset (rst, synchronous) returns to plain text mode, clears the spec and
// loads the configuration defaults; no clearing pass is needed.
// Configuration is written through cfg_we/cfg_index/cfg_data by the user
// only while idle; the block itself does not enforce this.
module terminal_padding_parser_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // char_in [7:0], affected_lines [23:8]
  input  logic [tpp_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  logic                              s_tlast,
  // is_alert_string [0]
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // char_out [7:0], delay_ms [35:8], zero fill [39:36]
  output logic [tpp_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                              m_tlast,
  // event_type [0]
  output logic                              m_tuser,
  input  logic                              cfg_we,
  input  logic [tpp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tpp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  tpp_pkg::tpp_cmd_t  cmd;
  tpp_pkg::tpp_stat_t st;

  tpp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  tpp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

[sim/tpp_stream_checker.sv]
// Scoreboard for the terminal padding parser: watches the byte, result and
// register write channels, predicts the result stream and compares it.
// Depends on tpp_pkg only.
module tpp_stream_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [tpp_pkg::IN_TDATA_W-1:0]   s_tdata,
  input  logic                             s_tlast,
  input  logic                             s_tuser,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [tpp_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic                             m_tlast,
  input  logic                             m_tuser,
  input  logic                             cfg_we,
  input  logic [tpp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tpp_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                               error_count,
  output int                               pending_count
);
  import tpp_pkg::*;

  typedef enum logic [2:0] {
    MD_TEXT,
    MD_DOLLAR,
    MD_OPEN,
    MD_INT,
    MD_FRAC1,
    MD_FRAC2,
    MD_SUFFIX
  } parse_mode_t;

  typedef enum logic [1:0] {
    SPEC_HELD,
    SPEC_DONE,
    SPEC_FAIL
  } spec_res_t;

  typedef struct packed {
    logic               event_type;
    logic [CHAR_W-1:0]  char_out;
    logic [DELAY_W-1:0] delay_ms;
    logic               run_last;
  } term_event_t;

  // Register mirror.
  logic              soft_flow;
  logic [RATE_W-1:0] pad_rate;
  logic [RATE_W-1:0] line_rate;

  // Parser state mirror.
  parse_mode_t       mode;
  logic [PAD_W-1:0]  pad_value;
  logic [CHAR_W-1:0] held_buf [HOLD_DEPTH];
  int                held_count;
  logic              delay_on;
  logic              string_start;

  term_event_t step_events[$];
  term_event_t expected_events[$];
  int          failures;

  function automatic void emit_event(input logic ev, input logic [CHAR_W-1:0] ch,
                                     input logic [DELAY_W-1:0] dly);
    term_event_t r;
    r.event_type = ev;
    r.char_out   = ch;
    r.delay_ms   = dly;
    r.run_last   = 1'b0;
    step_events.push_back(r);
  endfunction

  function automatic void clear_spec();
    mode       = MD_TEXT;
    held_count = 0;
    pad_value  = '0;
  endfunction

  // A broken spec goes out as typed: the opener and then every held byte.
  function automatic void replay_held();
    emit_event(1'b0, CH_DOLLAR, '0);
    emit_event(1'b0, CH_LT, '0);
    for (int i = 0; i < held_count; i++)
      emit_event(1'b0, held_buf[i], '0);
    clear_spec();
  endfunction

  function automatic void take_text_byte(input logic [CHAR_W-1:0] c);
    if (mode == MD_DOLLAR) begin
      if (c == CH_LT) begin
        clear_spec();
        mode = MD_OPEN;
      end else begin
        // The byte after a lone dollar passes through unexamined.
        emit_event(1'b0, CH_DOLLAR, '0);
        emit_event(1'b0, c, '0);
        mode = MD_TEXT;
      end
    end else if (c == CH_DOLLAR) begin
      mode = MD_DOLLAR;
    end else begin
      emit_event(1'b0, c, '0);
    end
  endfunction

  function automatic void take_suffix(input logic [CHAR_W-1:0] c,
                                      input logic [LINES_W-1:0] lines);
    if (c == CH_STAR)
      pad_value = pad_value * {{(PAD_W-LINES_W){1'b0}}, lines};
    else
      delay_on = 1'b1;
    mode = MD_SUFFIX;
  endfunction

  function automatic spec_res_t take_spec_byte(input logic [CHAR_W-1:0] c,
                                               input logic [LINES_W-1:0] lines);
    logic             dig;
    logic             sfx;
    logic [PAD_W-1:0] d;
    dig = (c >= CH_ZERO) && (c <= CH_NINE);
    sfx = (c == CH_STAR) || (c == CH_SLASH);
    d   = dig ? {24'b0, c - CH_ZERO} : '0;
    if (c == CH_GT && mode != MD_OPEN) begin
      if (mode == MD_INT)
        pad_value = pad_value * 32'd10;
      return SPEC_DONE;
    end
    if (held_count >= HOLD_DEPTH)
      return SPEC_FAIL;
    case (mode)
      MD_OPEN: begin
        if (dig) begin
          pad_value = d;
          mode = MD_INT;
        end else if (c == CH_DOT) begin
          pad_value = '0;
          mode = MD_FRAC1;
        end else begin
          return SPEC_FAIL;
        end
      end
      MD_INT: begin
        if (dig) begin
          if (pad_value >= PAD_LIMIT)
            return SPEC_FAIL;
          pad_value = pad_value * 32'd10 + d;
        end else if (c == CH_DOT) begin
          pad_value = pad_value * 32'd10;
          mode = MD_FRAC1;
        end else if (sfx) begin
          pad_value = pad_value * 32'd10;
          take_suffix(c, lines);
        end else begin
          return SPEC_FAIL;
        end
      end
      default: begin
        // Only the first digit after the point counts; later ones are held.
        if (dig && mode == MD_FRAC1) begin
          pad_value = pad_value + d;
          mode = MD_FRAC2;
        end else if (dig && mode == MD_FRAC2) begin
        end else if (sfx) begin
          take_suffix(c, lines);
        end else begin
          return SPEC_FAIL;
        end
      end
    endcase
    held_buf[held_count] = c;
    held_count++;
    return SPEC_HELD;
  endfunction

  function automatic void predict_byte(input logic [CHAR_W-1:0] c, input logic eos,
                                       input logic [LINES_W-1:0] lines, input logic alert);
    spec_res_t   res;
    term_event_t r;
    step_events.delete();
    if (string_start) begin
      delay_on = alert || (!soft_flow && pad_rate != '0 && line_rate >= pad_rate);
      string_start = 1'b0;
    end
    if (mode >= MD_OPEN) begin
      res = take_spec_byte(c, lines);
      if (res == SPEC_DONE) begin
        // The value is signed: zero and negative values give no delay.
        if (delay_on && pad_value != '0 && !pad_value[PAD_W-1])
          emit_event(1'b1, '0, DELAY_W'(pad_value / 32'd10));
        clear_spec();
      end else if (res == SPEC_FAIL) begin
        replay_held();
        take_text_byte(c);
      end
    end else begin
      take_text_byte(c);
    end
    if (eos) begin
      if (mode == MD_DOLLAR)
        emit_event(1'b0, CH_DOLLAR, '0);
      else if (mode >= MD_OPEN)
        replay_held();
      clear_spec();
      string_start = 1'b1;
    end
    for (int i = 0; i < step_events.size(); i++) begin
      r = step_events[i];
      r.run_last = (i == step_events.size() - 1);
      expected_events.push_back(r);
    end
  endfunction

  function automatic void check_result();
    term_event_t want;
    logic        bad;
    if (expected_events.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("%0t: unexpected result: type %0d char %02h delay %0d last %0d",
                 $time, m_tuser, m_tdata[7:0], m_tdata[35:8], m_tlast);
    end else begin
      want = expected_events.pop_front();
      bad = (m_tuser !== want.event_type) || (m_tdata[7:0] !== want.char_out) ||
            (m_tdata[35:8] !== want.delay_ms) || (m_tdata[39:36] !== 4'h0) ||
            (m_tlast !== want.run_last);
      if (bad) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t: result mismatch: expected type %0d char %02h delay %0d last %0d",
                   $time, want.event_type, want.char_out, want.delay_ms, want.run_last);
          $display("%0t:   got type %0d char %02h delay %0d last %0d fill %h",
                   $time, m_tuser, m_tdata[7:0], m_tdata[35:8], m_tlast, m_tdata[39:36]);
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      soft_flow    = 1'b0;
      pad_rate     = '0;
      line_rate    = LINE_RATE_RESET;
      delay_on     = 1'b0;
      string_start = 1'b1;
      clear_spec();
      expected_events.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SOFT_FLOW:    soft_flow = cfg_data[0];
          CFG_PADDING_RATE: pad_rate  = cfg_data[RATE_W-1:0];
          CFG_LINE_RATE:    line_rate = cfg_data[RATE_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        predict_byte(s_tdata[7:0], s_tlast, s_tdata[23:8], s_tuser);
      if (m_tvalid && m_tready)
        check_result();
    end
    pending_count <= expected_events.size();
    error_count   <= failures;
  end

endmodule

[sim/tb_terminal_padding_parser_unit.sv]
// Testbench top for terminal_padding_parser_unit: drives control strings and
// register settings, stalls the result side, and reports the verdict.
// Depends on tpp_pkg, the parser RTL and tpp_stream_checker.
module tb_terminal_padding_parser_unit;
  import tpp_pkg::*;

  localparam int                WATCHDOG_LIMIT = 5000;
  localparam int                NUM_PHASES     = 7;
  localparam int                PHASE_BYTES    = 26;
  localparam logic [RATE_W-1:0] MAX_RATE       = 23'd4194304;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   s_tlast;
  logic                   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   m_tuser;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int          error_count;
  int          pending_count;
  int          idle_cycles;
  int          sent_count;
  int          hold_off_len;
  logic        fast_mode;
  logic [7:0]  text_q[$];

  terminal_padding_parser_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tpp_stream_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .m_tuser       (m_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int draw_gap();
    if (fast_mode)
      return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic logic [LINES_W-1:0] draw_lines();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return LINES_W'($urandom_range(1, 5));
      2:       return '1;
      default: return LINES_W'($urandom());
    endcase
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 9))
      0:       return CH_DOLLAR;
      1:       return CH_LT;
      2:       return CH_GT;
      3:       return CH_DOT;
      4:       return CH_STAR;
      5:       return CH_SLASH;
      6, 7:    return CH_ZERO + 8'($urandom_range(0, 9));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] draw_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Hold each request until it is accepted; valid stays high into the
  // next request when no gap is drawn.
  task automatic send_byte(input logic [7:0] c, input logic eos,
                           input logic [LINES_W-1:0] lines, input logic alert);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {lines, c};
    s_tlast  <= eos;
    s_tuser  <= alert;
    do @(posedge clk); while (!s_tready);
    sent_count++;
  endtask

  // The alert flag only matters on the first byte; later ones get noise.
  task automatic send_text(input logic alert, input int lines_fixed);
    logic [LINES_W-1:0] lines;
    logic               a;
    for (int i = 0; i < text_q.size(); i++) begin
      lines = (lines_fixed >= 0) ? lines_fixed[LINES_W-1:0] : draw_lines();
      a = (i == 0) ? alert : 1'($urandom_range(0, 1));
      send_byte(text_q[i], i == text_q.size() - 1, lines, a);
    end
  endtask

  task automatic load_text(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++)
      text_q.push_back(s[i]);
  endtask

  // Mostly well-formed specs with random content; some are corrupted,
  // truncated, overlong or replaced by noise.
  task automatic build_random_text();
    int shape;
    int n;
    text_q.delete();
    shape = $urandom_range(0, 9);
    if (shape < 2) begin
      n = $urandom_range(1, 6);
      repeat (n) text_q.push_back(noise_byte());
    end else begin
      repeat ($urandom_range(0, 2)) text_q.push_back(8'($urandom_range(0, 255)));
      text_q.push_back(CH_DOLLAR);
      text_q.push_back(CH_LT);
      n = ($urandom_range(0, 9) == 0) ? 5 : $urandom_range(0, 4);
      repeat (n) text_q.push_back(draw_digit());
      if ($urandom_range(0, 1)) begin
        text_q.push_back(CH_DOT);
        // Now and then a tail long enough to fill the hold buffer.
        n = ($urandom_range(0, 11) == 0) ? $urandom_range(25, 40) : $urandom_range(0, 3);
        repeat (n) text_q.push_back(draw_digit());
      end
      repeat ($urandom_range(0, 2))
        text_q.push_back($urandom_range(0, 1) ? CH_STAR : CH_SLASH);
      if ($urandom_range(0, 9) != 0)
        text_q.push_back(CH_GT);
      if (shape < 4)
        text_q[$urandom_range(0, text_q.size() - 1)] = noise_byte();
      repeat ($urandom_range(0, 2)) text_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stop sending and let the block drain, including bytes with no result.
  // It first waits for the checker to update its pending count, so the count includes the results of the last request.
  task automatic drain(input int tail);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  initial begin : receiver
    int stall;
    m_tready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_off_len > 0) begin
        stall = hold_off_len;
        hold_off_len = 0;
      end else begin
        stall = draw_gap();
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin : stimulus
    int phase_start;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tlast      = 1'b0;
    s_tuser      = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_SOFT_FLOW;
    cfg_data     = '0;
    sent_count   = 0;
    hold_off_len = 0;
    fast_mode    = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Default registers: delay only for alert strings or after a slash.
    load_text("$<5>");
    send_text(1'b1, 0);
    load_text("$<1.5*/>");
    send_text(1'b0, 65535);
    load_text("$$x$");
    send_text(1'b0, -1);
    load_text("$<.>");
    send_text(1'b1, -1);
    load_text("$<12345");
    send_text(1'b0, -1);
    text_q.delete();
    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    send_text(1'b1, -1);

    for (int p = 1; p < NUM_PHASES; p++) begin
      drain(8);
      case (p)
        1: begin
          write_reg(CFG_SOFT_FLOW, '0);
          write_reg(CFG_PADDING_RATE, 23'd1);
          write_reg(CFG_LINE_RATE, MAX_RATE);
        end
        2: begin
          write_reg(CFG_SOFT_FLOW, 23'd1);
          write_reg(CFG_PADDING_RATE, 23'd9600);
          write_reg(CFG_LINE_RATE, 23'd9600);
        end
        3: begin
          write_reg(CFG_SOFT_FLOW, '0);
          write_reg(CFG_PADDING_RATE, MAX_RATE);
          write_reg(CFG_LINE_RATE, MAX_RATE);
        end
        4: write_reg(CFG_LINE_RATE, '0);
        5: begin
          write_reg(CFG_PADDING_RATE, '0);
          write_reg(CFG_LINE_RATE, 23'($urandom_range(0, MAX_RATE)));
        end
        default: begin
          write_reg(CFG_SOFT_FLOW, 23'($urandom_range(0, 1)));
          write_reg(CFG_PADDING_RATE, 23'($urandom_range(0, MAX_RATE)));
          write_reg(CFG_LINE_RATE, 23'($urandom_range(0, MAX_RATE)));
        end
      endcase
      fast_mode = (p == 2);
      // The receiver holds off while bytes keep coming, so the block backs up.
      if (p == 1)
        hold_off_len = 400;
      phase_start = sent_count;
      while (sent_count - phase_start < PHASE_BYTES) begin
        build_random_text();
        send_text($urandom_range(0, 3) == 0, -1);
      end
    end

    drain(20);
    if (error_count == 0 && pending_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

[files.f]
sv/tpp_pkg.sv
sv/tpp_datapath.sv
sv/tpp_ctrl.sv
sv/terminal_padding_parser_unit.sv
sim/tpp_stream_checker.sv
sim/tb_terminal_padding_parser_unit.sv
